@@ rtl/msa_pkg.sv @@
// Package for the max-distance seat allocator: status and command codes,
// controller state type and the command/status bundles between modules.
// No dependencies.
`default_nettype none

package msa_pkg;

   localparam int unsigned SEAT_IN_W = 8;
   localparam int unsigned CFG_W     = 9;
   localparam int unsigned STATUS_W  = 2;

   localparam logic [CFG_W-1:0] SEAT_COUNT_RESET = 9'd256;

   localparam logic CMD_TAKE    = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_REL_READ,
      S_FINISH
   } msa_state_type;

   typedef struct packed {
      logic clear;      // clearing pass: zero one map entry
      logic start;      // item accepted: latch it and reset the scan
      logic scan_read;  // read the next seat of the map
      logic rel_read;   // read the seat named by a release
      logic finish;     // load the result and update the map
   } msa_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scan_last;
      logic out_free;
   } msa_stat_type;

endpackage

`default_nettype wire

@@ rtl/msa_ctrl.sv @@
// Controller of the seat allocator: sequences the clearing pass, the map
// scan for take and the read-modify-write for release. Uses msa_pkg.
`default_nettype none

module msa_ctrl
   import msa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tuser,
   output logic              req_tready,
   input  wire msa_stat_type stat,
   output msa_cmd_type       cmd
);

   msa_state_type state_ff;
   msa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == CMD_RELEASE) ? S_REL_READ : S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN:    state_in = S_FINISH;
         S_REL_READ: state_in = S_FINISH;
         S_FINISH: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default:    state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR:    cmd.clear = 1'b1;
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         S_SCAN:     cmd.scan_read = 1'b1;
         S_DRAIN:    cmd = '0;
         S_REL_READ: cmd.rel_read = 1'b1;
         S_FINISH:   cmd.finish = stat.out_free;
         default:    cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/msa_datapath.sv @@
// Datapath of the seat allocator: occupancy memory, seat-count register,
// gap tracking for the scan and the result register. Uses msa_pkg.
`default_nettype none

module msa_datapath
   import msa_pkg::*;
#(
   parameter int unsigned MAX_SEATS = 256,
   parameter int unsigned SEAT_W    = 8,
   parameter int unsigned CMP_W     = 9
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire msa_cmd_type          cmd,
   output msa_stat_type              stat,
   input  wire logic                 csr_wr_en,
   input  wire logic [CFG_W-1:0]     csr_wr_data,
   input  wire logic                 req_tuser,
   input  wire logic [SEAT_IN_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [SEAT_IN_W-1:0]      rsp_tdata,
   output logic [STATUS_W-1:0]       rsp_tuser
);

   localparam logic [CMP_W-1:0]  MAX_WIDE  = CMP_W'(MAX_SEATS);
   localparam logic [SEAT_W-1:0] LAST_SEAT = SEAT_W'(MAX_SEATS - 1);

   logic                  mem [MAX_SEATS];
   logic                  mem_we;
   logic [SEAT_W-1:0]     mem_waddr;
   logic                  mem_wdata;
   logic                  mem_re;
   logic [SEAT_W-1:0]     mem_raddr;
   logic                  rdata_ff;

   logic [CFG_W-1:0]      csr_ff;
   logic [CMP_W-1:0]      n_eff;
   logic [CMP_W-1:0]      req_wide;

   logic [SEAT_W-1:0]     idx_ff,       idx_in;
   logic                  pvalid_ff;
   logic [SEAT_W-1:0]     pidx_ff;
   logic                  is_rel_ff;
   logic [SEAT_IN_W-1:0]  seat_in_ff;
   logic [SEAT_W-1:0]     rel_addr_ff;
   logic                  in_range_ff;
   logic [SEAT_W-1:0]     n_last_ff;

   logic                  any_ff,       any_in;
   logic [SEAT_W-1:0]     last_ff,      last_in;
   logic [SEAT_W-1:0]     best_dist_ff, best_dist_in;
   logic [SEAT_W-1:0]     best_seat_ff, best_seat_in;
   logic [SEAT_W-1:0]     gap_d;

   logic [SEAT_W-1:0]     end_d;
   logic [SEAT_W-1:0]     fin_dist;
   logic [SEAT_W-1:0]     fin_seat;
   logic                  rel_ok;
   logic [SEAT_IN_W-1:0]  res_seat;
   logic [STATUS_W-1:0]   res_status;

   logic                  rsp_valid_ff;
   logic [SEAT_IN_W-1:0]  rsp_seat_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   // Seat count saturated to the range one to MAX_SEATS.
   always_comb begin
      if (csr_ff == '0) begin
         n_eff = CMP_W'(1);
      end else if (CMP_W'(csr_ff) > MAX_WIDE) begin
         n_eff = MAX_WIDE;
      end else begin
         n_eff = CMP_W'(csr_ff);
      end
   end

   assign req_wide = CMP_W'(req_tdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= SEAT_COUNT_RESET;
      end else if (csr_wr_en) begin
         csr_ff <= csr_wr_data;
      end
   end

   // Occupancy memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   assign mem_re    = cmd.scan_read | cmd.rel_read;
   assign mem_raddr = cmd.scan_read ? idx_ff : rel_addr_ff;

   // Seat counter shared by the clearing pass and the scan.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.start) begin
         idx_in = '0;
      end else if (cmd.clear || cmd.scan_read) begin
         idx_in = idx_ff + SEAT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         pvalid_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         pvalid_ff <= cmd.scan_read;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= idx_ff;
      if (cmd.start) begin
         is_rel_ff   <= req_tuser;
         seat_in_ff  <= req_tdata;
         rel_addr_ff <= SEAT_W'(req_wide);
         in_range_ff <= req_wide < n_eff;
         n_last_ff   <= SEAT_W'(n_eff - CMP_W'(1));
      end
   end

   // Gap tracking: each occupied seat closes the gap that started at the
   // previous one; the gap in front of the first occupied one goes to seat 0.
   assign gap_d = (pidx_ff - last_ff) >> 1;

   always_comb begin
      any_in       = any_ff;
      last_in      = last_ff;
      best_dist_in = best_dist_ff;
      best_seat_in = best_seat_ff;
      if (cmd.start) begin
         any_in       = 1'b0;
         last_in      = '0;
         best_dist_in = '0;
         best_seat_in = '0;
      end else if (pvalid_ff && rdata_ff) begin
         if (!any_ff) begin
            any_in       = 1'b1;
            best_dist_in = pidx_ff;
            best_seat_in = '0;
         end else if (gap_d > best_dist_ff) begin
            best_dist_in = gap_d;
            best_seat_in = last_ff + gap_d;
         end
         last_in = pidx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff <= 1'b0;
      end else begin
         any_ff <= any_in;
      end
      last_ff      <= last_in;
      best_dist_ff <= best_dist_in;
      best_seat_ff <= best_seat_in;
   end

   // Final choice: the gap after the last occupied seat picks the last seat only if strictly wider.
   assign end_d = n_last_ff - last_ff;

   always_comb begin
      if (end_d > best_dist_ff) begin
         fin_dist = end_d;
         fin_seat = n_last_ff;
      end else begin
         fin_dist = best_dist_ff;
         fin_seat = best_seat_ff;
      end
   end

   assign rel_ok = in_range_ff & rdata_ff;

   always_comb begin
      mem_we     = 1'b0;
      mem_waddr  = idx_ff;
      mem_wdata  = 1'b0;
      res_seat   = seat_in_ff;
      res_status = ST_OK;
      if (cmd.clear) begin
         mem_we = 1'b1;
      end else if (is_rel_ff == CMD_RELEASE) begin
         res_status = rel_ok ? ST_OK : ST_BAD;
         mem_we     = cmd.finish & rel_ok;
         mem_waddr  = rel_addr_ff;
      end else if (!any_ff) begin
         res_seat  = '0;
         mem_we    = cmd.finish;
         mem_waddr = '0;
         mem_wdata = 1'b1;
      end else if (fin_dist == '0) begin
         res_seat   = '0;
         res_status = ST_FULL;
      end else begin
         res_seat  = SEAT_IN_W'(fin_seat);
         mem_we    = cmd.finish;
         mem_waddr = fin_seat;
         mem_wdata = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_seat_ff   <= res_seat;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_seat_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign stat.clear_last = (idx_ff == LAST_SEAT);
   assign stat.scan_last  = (idx_ff == n_last_ff);
   assign stat.out_free   = ~rsp_valid_ff | rsp_tready;

endmodule

`default_nettype wire

@@ rtl/max_distance_seat_allocator_unit.sv @@
// Top level of the max-distance seat allocator: controller and datapath.
// Depends on msa_pkg, msa_ctrl and msa_datapath.
//
//   Channel   Direction  tdata (low bit up)   tuser (low bit up)
//   req_      in         seat_in[7:0]         command[0]
//   rsp_      out        seat_out[7:0]        status[1:0]
//   csr_      in         seat_count[8:0]      -
//
// In a take the scan reads the occupancy memory one seat per cycle through
// its read port, over all seats below the effective seat count. A release
// takes one read and one write of the memory. After reset a clearing pass
// zeroes all MAX_SEATS entries of the memory; req_tready stays low meanwhile.
// One item is in work at a time; a result waits in the output register, and
// the next item is accepted meanwhile.
`default_nettype none

module max_distance_seat_allocator_unit
   import msa_pkg::*;
#(
   parameter int unsigned MAX_SEATS = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [SEAT_IN_W-1:0] req_tdata,   // seat_in[7:0]
   input  wire logic                 req_tuser,   // command[0]
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [SEAT_IN_W-1:0]      rsp_tdata,   // seat_out[7:0]
   output logic [STATUS_W-1:0]       rsp_tuser,   // status[1:0]
   input  wire logic                 csr_wr_en,
   input  wire logic [CFG_W-1:0]     csr_wr_data  // seat_count[8:0]
);

   localparam int unsigned SEAT_W = $clog2(MAX_SEATS);
   localparam int unsigned CNT_W  = $clog2(MAX_SEATS + 1);
   localparam int unsigned CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   msa_cmd_type  cmd;
   msa_stat_type stat;

   msa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   msa_datapath #(
      .MAX_SEATS (MAX_SEATS),
      .SEAT_W    (SEAT_W),
      .CMP_W     (CMP_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // The clearing pass must hold off input items right after reset.
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("input accepted during the clearing pass");

   // Only one item is in work at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while one is in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK || rsp_tuser == ST_FULL ||
                      rsp_tuser == ST_BAD))
      else $error("undefined status code on the result");

   a_full_seat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |-> rsp_tdata == '0)
      else $error("room-full result carries a non-zero seat");

endmodule

`default_nettype wire

@@ sim/tb_max_distance_seat_allocator_unit.sv @@
// Self-checking bench for max_distance_seat_allocator_unit: a directed table, then random
// take and release traffic over several seat counts, checked against an occupancy-map model.
// Depends on msa_pkg and the allocator RTL.
module tb_max_distance_seat_allocator_unit
   import msa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SEATS     = 256;
   localparam int ITEMS_PER_SET = 38;
   localparam int NUM_SETS      = 12;

   typedef struct packed {
      logic [SEAT_IN_W-1:0] seat;
      logic [STATUS_W-1:0]  status;
   } seat_result_type;

   typedef enum logic [1:0] {
      ROW_CONFIG,
      ROW_PREDICT,
      ROW_TYPED
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic                 cmd;
      logic [CFG_W-1:0]     value;
      logic [SEAT_IN_W-1:0] exp_seat;
      logic [STATUS_W-1:0]  exp_status;
   } dir_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [SEAT_IN_W-1:0] req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [SEAT_IN_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]  rsp_tuser;
   logic                 csr_wr_en;
   logic [CFG_W-1:0]     csr_wr_data;

   // Model state: seat occupancy and the seat count register.
   bit               seat_map [0:MAX_SEATS-1];
   logic [CFG_W-1:0] seat_limit;
   seat_result_type  seat_results_q [$];
   int               error_count;
   int               send_idle_pct;
   int               recv_idle_pct;

   max_distance_seat_allocator_unit #(
      .MAX_SEATS(MAX_SEATS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int effective_seats();
      if (seat_limit == 0) return 1;
      if (seat_limit > MAX_SEATS) return MAX_SEATS;
      return int'(seat_limit);
   endfunction

   // Applies one command to the occupancy map and returns the result it gives.
   function automatic void allocate_seat(input logic cmd, input logic [SEAT_IN_W-1:0] seat_req,
                                         output seat_result_type res);
      int  n;
      int  last;
      int  best_dist;
      int  best_seat;
      bit  any;
      n = effective_seats();
      if (cmd == CMD_RELEASE) begin
         res.seat   = seat_req;
         res.status = ST_BAD;
         if (seat_req < n && seat_map[seat_req]) begin
            seat_map[seat_req] = 1'b0;
            res.status = ST_OK;
         end
         return;
      end
      any = 1'b0;
      last = 0;
      best_dist = 0;
      best_seat = 0;
      for (int i = 0; i < n; i++) begin
         if (seat_map[i]) begin
            if (!any) begin
               // The gap in front of the first occupied seat is served by seat 0.
               best_dist = i;
               best_seat = 0;
               any = 1'b1;
            end else if ((i - last) / 2 > best_dist) begin
               best_dist = (i - last) / 2;
               best_seat = last + best_dist;
            end
            last = i;
         end
      end
      if (!any) begin
         seat_map[0] = 1'b1;
         res.seat   = '0;
         res.status = ST_OK;
         return;
      end
      if (n - 1 - last > best_dist) begin
         best_dist = n - 1 - last;
         best_seat = n - 1;
      end
      if (best_dist == 0) begin
         res.seat   = '0;
         res.status = ST_FULL;
         return;
      end
      seat_map[best_seat] = 1'b1;
      res.seat   = best_seat[SEAT_IN_W-1:0];
      res.status = ST_OK;
   endfunction

   task automatic report_error(input string msg);
      $display("%0t: %s", $time, msg);
      error_count++;
   endtask

   // Offers one item, waits for it to be taken and queues the result it should give.
   task automatic send_item(input logic cmd, input logic [SEAT_IN_W-1:0] seat, input bit typed,
                            input seat_result_type typed_res);
      seat_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= seat;
      do @(posedge clock); while (!req_tready);
      allocate_seat(cmd, seat, res);
      if (typed) res = typed_res;
      seat_results_q.push_back(res);
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (seat_results_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_seat_count(input logic [CFG_W-1:0] value);
      wait_results_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      seat_limit = value;
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      seat_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (seat_results_q.size() == 0) begin
            report_error($sformatf("unexpected result seat %0d status %0d",
                                   rsp_tdata, rsp_tuser));
         end else begin
            want = seat_results_q.pop_front();
            if (rsp_tdata !== want.seat)
               report_error($sformatf("seat_out got %0d expected %0d", rsp_tdata, want.seat));
            if (rsp_tuser !== want.status)
               report_error($sformatf("status got %0d expected %0d", rsp_tuser, want.status));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      dir_row_type     plan [0:26];
      int              set_seats [0:NUM_SETS-1];
      int              occ [$];
      int              total;
      int              k;
      int              pick;
      logic [7:0]      rseat;
      seat_result_type none;

      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_TAKE;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      seat_limit  = SEAT_COUNT_RESET;
      error_count = 0;
      none        = '0;
      send_idle_pct = 34;
      recv_idle_pct = 66;

      plan = '{
         '{ROW_TYPED,   CMD_TAKE,    9'd0,   8'd0,   ST_OK},   // empty room after reset
         '{ROW_TYPED,   CMD_TAKE,    9'd0,   8'd255, ST_OK},
         '{ROW_TYPED,   CMD_TAKE,    9'd0,   8'd127, ST_OK},
         '{ROW_TYPED,   CMD_RELEASE, 9'd255, 8'd255, ST_OK},
         '{ROW_TYPED,   CMD_RELEASE, 9'd255, 8'd255, ST_BAD},  // seat already free
         '{ROW_CONFIG,  CMD_TAKE,    9'd1,   8'd0,   ST_OK},
         '{ROW_TYPED,   CMD_TAKE,    9'd0,   8'd0,   ST_FULL},
         '{ROW_TYPED,   CMD_RELEASE, 9'd1,   8'd1,   ST_BAD},  // beyond the seat count
         '{ROW_TYPED,   CMD_RELEASE, 9'd0,   8'd0,   ST_OK},
         '{ROW_TYPED,   CMD_TAKE,    9'd0,   8'd0,   ST_OK},
         '{ROW_CONFIG,  CMD_TAKE,    9'd0,   8'd0,   ST_OK},   // zero behaves as one
         '{ROW_TYPED,   CMD_TAKE,    9'd0,   8'd0,   ST_FULL},
         '{ROW_CONFIG,  CMD_TAKE,    9'd511, 8'd0,   ST_OK},   // saturates to the maximum
         '{ROW_PREDICT, CMD_TAKE,    9'd0,   8'd0,   ST_OK},
         '{ROW_CONFIG,  CMD_TAKE,    9'd2,   8'd0,   ST_OK},
         '{ROW_PREDICT, CMD_TAKE,    9'd0,   8'd0,   ST_OK},
         '{ROW_PREDICT, CMD_TAKE,    9'd0,   8'd0,   ST_OK},
         '{ROW_TYPED,   CMD_RELEASE, 9'd255, 8'd255, ST_BAD},  // occupied but hidden by shrink
         '{ROW_CONFIG,  CMD_TAKE,    9'd256, 8'd0,   ST_OK},
         '{ROW_PREDICT, CMD_RELEASE, 9'd255, 8'd0,   ST_OK},
         '{ROW_PREDICT, CMD_RELEASE, 9'd200, 8'd0,   ST_OK},
         '{ROW_CONFIG,  CMD_TAKE,    9'd7,   8'd0,   ST_OK},
         '{ROW_PREDICT, CMD_RELEASE, 9'd0,   8'd0,   ST_OK},
         '{ROW_PREDICT, CMD_RELEASE, 9'd1,   8'd0,   ST_OK},
         '{ROW_PREDICT, CMD_TAKE,    9'd0,   8'd0,   ST_OK},
         '{ROW_PREDICT, CMD_TAKE,    9'd0,   8'd0,   ST_OK},
         '{ROW_PREDICT, CMD_TAKE,    9'd0,   8'd0,   ST_OK}
      };
      set_seats = '{4, 1, 9, 256, 2, 17, 0, 33, 511, 6, 3, 48};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CONFIG)
            write_seat_count(plan[r].value);
         else
            send_item(plan[r].cmd, plan[r].value[7:0], plan[r].kind == ROW_TYPED,
                      seat_result_type'{plan[r].exp_seat, plan[r].exp_status});
      end

      total = NUM_SETS * ITEMS_PER_SET;
      k = 0;
      for (int s = 0; s < NUM_SETS; s++) begin
         write_seat_count(set_seats[s][CFG_W-1:0]);
         for (int j = 0; j < ITEMS_PER_SET; j++) begin
            if (k < total / 3) begin
               send_idle_pct = 34;
               recv_idle_pct = 66;
            end else if (k < 2 * total / 3) begin
               send_idle_pct = 66;
               recv_idle_pct = 34;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            // Now and then hold off until the block has handed out everything.
            if ($urandom_range(39) == 0) wait_results_drained();
            occ.delete();
            for (int i = 0; i < effective_seats(); i++)
               if (seat_map[i]) occ.push_back(i);
            pick  = $urandom_range(99);
            rseat = 8'($urandom_range(255));
            if (pick < 15)
               send_item(CMD_RELEASE, rseat, 1'b0, none);
            else if (pick < 45 && occ.size() > 0)
               send_item(CMD_RELEASE, 8'(occ[$urandom_range(occ.size() - 1)]), 1'b0, none);
            else
               send_item(CMD_TAKE, rseat, 1'b0, none);
            k++;
         end
      end

      wait_results_drained();
      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
